/* src/m3am_pkg.sv */
// Package for the 3x3 matrix add/multiply core: sizes, word structs and
// the pipeline tag passed from the sequencer to the datapath.
// No dependencies; used by m3am_mac and matrix3_add_multiply_core.
`default_nettype none

package m3am_pkg;

  localparam int DIM     = 3;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 2;
  localparam int ENTRIES = DIM * DIM;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int STEP_W  = $clog2(DIM + 1);

  // Input word: one matrix element load.
  typedef struct packed {
    logic signed [DATA_W-1:0] elem_value;
    logic                     matrix_sel;
    logic [IDX_W-1:0]         elem_row;
    logic [IDX_W-1:0]         elem_col;
    logic                     load_done;
  } in_t;

  // Result word: one position of A+B and A*B.
  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] sum_value;
    logic signed [DATA_W-1:0] prod_value;
    logic                     last_result;
  } out_t;

  // Describes the memory read issued in one cycle.
  typedef struct packed {
    logic             valid;
    logic             sum_step;  // read of A[r][c] and B[r][c]
    logic             first;     // first term of the dot product
    logic             last_k;    // last term: the result word is complete
    logic             final_pos; // last position of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

/* src/m3am_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module m3am_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/m3am_mac.sv */
// Datapath: element sum, registered multiply and dot-product accumulator,
// plus the result register. Depends on m3am_pkg.
`default_nettype none

module m3am_mac (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire m3am_pkg::tag_t           tag_i,
  input  wire logic [m3am_pkg::DATA_W-1:0] a_i,
  input  wire logic [m3am_pkg::DATA_W-1:0] b_i,
  output logic                          res_valid_o,
  output m3am_pkg::out_t                res_o
);
  import m3am_pkg::*;

  tag_t              tag2_q;
  logic [DATA_W-1:0] sum_q;
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] acc_d;
  logic              res_valid_q;
  out_t              res_q;

  // Stage one: memory data is valid alongside tag_i.
  always_ff @(posedge clk_i) begin
    if (tag_i.valid && tag_i.sum_step) begin
      sum_q <= a_i + b_i;
    end
    if (tag_i.valid && !tag_i.sum_step) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
    end else begin
      tag2_q <= tag_i;
    end
  end

  // Stage two: accumulate. The sum of this position is still held in sum_q
  // here, as the next sum is written at the edge that registers res_q.
  assign acc_d = (tag2_q.first ? '0 : acc_q) + prod_q;

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid && !tag2_q.sum_step) begin
      acc_q <= acc_d;
    end
    if (tag2_q.valid && tag2_q.last_k) begin
      res_q.out_row     <= tag2_q.row;
      res_q.out_col     <= tag2_q.col;
      res_q.sum_value   <= sum_q;
      res_q.prod_value  <= acc_d;
      res_q.last_result <= tag2_q.final_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tag2_q.valid && tag2_q.last_k;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* src/matrix3_add_multiply_core.sv */
// Top level of the 3x3 matrix add/multiply core: load sequencing, the two
// element memories and the run sequencer. Depends on m3am_pkg, m3am_ram
// and m3am_mac.
//
// Usage: each word on in_i loads one element of A (matrix_sel = 0) or B
// (matrix_sel = 1); it is taken at a rising edge with start high and busy
// low. A word whose row or column is out of range stores nothing. A word
// with load_done set stores its element and starts a run; busy then stays
// high until the last result is on the outputs.
// A run emits nine result words in row-major order, each shown on res_o for
// one cycle with res_valid_o high; the receiver cannot stall them.
// Load words can follow one another back to back while busy is low. Every
// result position takes four reads of each memory (one for the sum, three
// for the dot product), since each memory has a single read port. Through
// the pipeline of read, multiply, accumulate and result register, the
// result words appear one per position, and the last is taken at the same
// edge that lowers busy.
// Reset clears the control state only; the memory contents are undefined
// until written and persist from one run to the next.
`default_nettype none

module matrix3_add_multiply_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire m3am_pkg::in_t   in_i,
  output logic                 res_valid_o,
  output m3am_pkg::out_t       res_o
);
  import m3am_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  col_q, col_d;
  logic [STEP_W-1:0] step_q, step_d;
  tag_t              tag_q, tag_d;

  logic              accept;
  logic              in_range;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] k_idx;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  logic              last_step, last_col, last_row;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);

  assign in_range = (in_i.elem_row < IDX_W'(DIM)) && (in_i.elem_col < IDX_W'(DIM));
  assign waddr    = ADDR_W'(in_i.elem_row) * ADDR_W'(DIM) + ADDR_W'(in_i.elem_col);
  assign we_a     = accept && in_range && !in_i.matrix_sel;
  assign we_b     = accept && in_range && in_i.matrix_sel;

  // Step zero reads A[r][c] and B[r][c]; step k+1 reads A[r][k] and B[k][c].
  assign k_idx = ADDR_W'(step_q) - ADDR_W'(1);

  always_comb begin
    if (step_q == '0) begin
      raddr_a = ADDR_W'(row_q) * ADDR_W'(DIM) + ADDR_W'(col_q);
      raddr_b = raddr_a;
    end else begin
      raddr_a = ADDR_W'(row_q) * ADDR_W'(DIM) + k_idx;
      raddr_b = k_idx * ADDR_W'(DIM) + ADDR_W'(col_q);
    end
  end

  assign last_step = (step_q == STEP_W'(DIM));
  assign last_col  = (col_q == IDX_W'(DIM - 1));
  assign last_row  = (row_q == IDX_W'(DIM - 1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    step_d  = step_q;

    tag_d           = '0;
    tag_d.valid     = (state_q == ST_RUN);
    tag_d.sum_step  = (step_q == '0);
    tag_d.first     = (step_q == STEP_W'(1));
    tag_d.last_k    = last_step;
    tag_d.final_pos = last_step && last_col && last_row;
    tag_d.row       = row_q;
    tag_d.col       = col_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.load_done) begin
          state_d = ST_RUN;
          row_d   = '0;
          col_d   = '0;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          step_d = '0;
          if (last_col) begin
            col_d = '0;
            if (last_row) begin
              state_d = ST_DRAIN;
            end else begin
              row_d = row_q + IDX_W'(1);
            end
          end else begin
            col_d = col_q + IDX_W'(1);
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (res_valid_o && res_o.last_result) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      step_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      step_q  <= step_d;
      tag_q   <= tag_d;
    end
  end

  m3am_ram #(
    .Width (DATA_W),
    .Depth (ENTRIES)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_i.elem_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  m3am_ram #(
    .Width (DATA_W),
    .Depth (ENTRIES)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_i.elem_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  m3am_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .a_i         (rdata_a),
    .b_i         (rdata_b),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
